// ----- rtl/core/pic_pkg.sv -----
// Package for the programmable interrupt controller.
// Holds the action codes, command bit positions, init step states and the request and result types.
// No dependencies.
`default_nettype none

package pic_pkg;

  typedef enum logic [2:0] {
    ACT_WRITE = 3'd0,
    ACT_READ  = 3'd1,
    ACT_RAISE = 3'd2,
    ACT_LOWER = 3'd3,
    ACT_ACK   = 3'd4
  } action_e;

  // Initialization sequence after ICW1.
  typedef enum logic [2:0] {
    INIT_IDLE = 3'b001,
    INIT_ICW2 = 3'b010,
    INIT_ICW4 = 3'b100
  } init_step_e;

  // Bit positions in an even-port command byte.
  localparam int unsigned IcwOneBit   = 4;
  localparam int unsigned OcwThreeBit = 3;
  localparam int unsigned EoiBit      = 5;
  localparam int unsigned SpecificBit = 6;
  localparam int unsigned IcwFourBit  = 0;

  localparam logic [7:0] MaskResetVal = 8'hFF;

  typedef struct packed {
    logic [2:0] action;
    logic       port_odd;
    logic [7:0] write_data;
    logic [2:0] irq_line;
  } pic_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       vector_valid;
    logic [7:0] vector_number;
  } pic_res_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [2:0] lowest_index(input logic [7:0] bits);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (bits[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/programmable_interrupt_controller_unit.sv -----
// Throughput: one request per cycle while the output is not stalled; the register update
// and priority encode finish between the input register and the result register.
// Reset: asynchronous, active low; both stages empty, mask all ones, init step idle, other core state zero.
// Top level of the interrupt controller: input register, core and result register.
// Depends on pic_pkg and pic_core.
`default_nettype none

module programmable_interrupt_controller_unit
  import pic_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] action_i,
  input  wire logic       port_odd_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic [2:0] irq_line_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      read_data_o,
  output logic            vector_valid_o,
  output logic [7:0]      vector_number_o
);

  logic     in_valid_q;
  pic_req_t in_req_q;
  logic     out_valid_q;
  pic_res_t out_res_q;
  pic_res_t core_res;
  logic     advance;
  logic     in_take;

  // The held request moves on when the result register is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= '{action: action_i, port_odd: port_odd_i,
                    write_data: write_data_i, irq_line: irq_line_i};
    end
  end

  pic_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (in_req_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_res_q.read_data;
  assign vector_valid_o  = out_res_q.vector_valid;
  assign vector_number_o = out_res_q.vector_number;

endmodule

`default_nettype wire

// ----- rtl/core/pic_core.sv -----
// Register file and update logic of the interrupt controller.
// Holds request, in-service and mask bytes, the init sequence and the vector base.
// Depends on pic_pkg.
`default_nettype none

module pic_core
  import pic_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire pic_req_t req_i,
  output pic_res_t      res_o
);

  logic [7:0] request_q, request_d;
  logic [7:0] service_q, service_d;
  logic [7:0] mask_q, mask_d;
  init_step_e init_q, init_d;
  logic       expect_icw4_q, expect_icw4_d;
  logic [4:0] vector_high_q, vector_high_d;

  logic [7:0] pend;
  logic [7:0] upto;
  logic [2:0] grant_idx;
  logic       grant;
  logic [7:0] line_bit;
  logic [7:0] d;

  assign d         = req_i.write_data;
  assign line_bit  = 8'h01 << req_i.irq_line;
  assign pend      = request_q & ~mask_q;
  // All bits up to and including the lowest pending line.
  assign upto      = pend ^ (pend - 8'd1);
  assign grant_idx = lowest_index(pend);
  assign grant     = (pend != 8'd0) && ((service_q & upto) == 8'd0);

  always_comb begin
    request_d     = request_q;
    service_d     = service_q;
    mask_d        = mask_q;
    init_d        = init_q;
    expect_icw4_d = expect_icw4_q;
    vector_high_d = vector_high_q;
    res_o         = '0;

    case (req_i.action)
      ACT_WRITE: begin
        if (req_i.port_odd) begin
          if (init_q == INIT_ICW2) begin
            vector_high_d = d[7:3];
            init_d        = expect_icw4_q ? INIT_ICW4 : INIT_IDLE;
          end else if (init_q != INIT_IDLE) begin
            init_d = INIT_IDLE;
          end else begin
            mask_d = d;
          end
        end else if (d[IcwOneBit]) begin
          init_d        = INIT_ICW2;
          expect_icw4_d = d[IcwFourBit];
          request_d     = 8'd0;
          service_d     = 8'd0;
          mask_d        = 8'd0;
        end else if (!d[OcwThreeBit] && d[EoiBit]) begin
          if (d[SpecificBit]) begin
            service_d = service_q & ~(8'h01 << d[2:0]);
          end else begin
            service_d = service_q & (service_q - 8'd1);
          end
        end
      end
      ACT_READ: begin
        res_o.read_data = req_i.port_odd ? mask_q : request_q;
      end
      ACT_RAISE: begin
        request_d = request_q | line_bit;
      end
      ACT_LOWER: begin
        request_d = request_q & ~line_bit;
      end
      ACT_ACK: begin
        if (grant) begin
          service_d           = service_q | (8'h01 << grant_idx);
          request_d           = request_q & ~(8'h01 << grant_idx);
          res_o.vector_valid  = 1'b1;
          res_o.vector_number = {vector_high_q, grant_idx};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      request_q     <= 8'd0;
      service_q     <= 8'd0;
      mask_q        <= MaskResetVal;
      init_q        <= INIT_IDLE;
      expect_icw4_q <= 1'b0;
      vector_high_q <= 5'd0;
    end else if (en_i) begin
      request_q     <= request_d;
      service_q     <= service_d;
      mask_q        <= mask_d;
      init_q        <= init_d;
      expect_icw4_q <= expect_icw4_d;
      vector_high_q <= vector_high_d;
    end
  end

endmodule

`default_nettype wire

// ----- dv/programmable_interrupt_controller_unit_tb.sv -----
// Testbench for programmable_interrupt_controller_unit: queued requests, random handshake gaps,
// in-order checking of every response against a cycle-free model of the controller.
// Depends on pic_pkg and the controller RTL.
`timescale 1ns / 100ps

module programmable_interrupt_controller_unit_tb;
  import pic_pkg::*;

  localparam int RandomItems  = 1400;
  localparam int IdlePercent  = 32;
  localparam int CalmFirst    = 500;
  localparam int CalmLast     = 800;
  localparam int DrainCycles  = 10;
  localparam int TimeoutNs    = 4_000_000;
  localparam int MaxReported  = 10;

  // Even-port command bytes built from the package bit positions.
  localparam logic [7:0] Icw1Cmd    = 8'(1 << IcwOneBit);
  localparam logic [7:0] Icw4Flag   = 8'(1 << IcwFourBit);
  localparam logic [7:0] Ocw3Cmd    = 8'(1 << OcwThreeBit);
  localparam logic [7:0] EoiCmd     = 8'(1 << EoiBit);
  localparam logic [7:0] SpecEoiCmd = 8'((1 << EoiBit) | (1 << SpecificBit));

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic [2:0] action_i       = '0;
  logic       port_odd_i     = 1'b0;
  logic [7:0] write_data_i   = '0;
  logic [2:0] irq_line_i     = '0;
  logic       out_stall_i    = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] read_data_o;
  logic       vector_valid_o;
  logic [7:0] vector_number_o;

  programmable_interrupt_controller_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .port_odd_i     (port_odd_i),
    .write_data_i   (write_data_i),
    .irq_line_i     (irq_line_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_data_o    (read_data_o),
    .vector_valid_o (vector_valid_o),
    .vector_number_o(vector_number_o)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Model state of the controller.
  logic [7:0] irr_model;
  logic [7:0] isr_model;
  logic [7:0] imr_model;
  init_step_e init_model;
  logic       icw4_wanted;
  logic [4:0] base_model;

  pic_req_t pending_requests[$];
  pic_res_t expected_responses[$];
  pic_req_t current_request;

  int total_items    = 0;
  int accepted_count = 0;
  int response_count = 0;
  int grants_seen    = 0;
  int init_sequences = 0;
  int mismatches     = 0;

  // Applies one request to the model state and returns the response it produces.
  function automatic pic_res_t controller_response(pic_req_t r);
    pic_res_t   res;
    logic [7:0] pend;
    logic [7:0] upto;
    int         lvl;
    res = '0;
    case (r.action)
      ACT_WRITE: begin
        if (!r.port_odd) begin
          if (r.write_data[IcwOneBit]) begin
            init_model  = INIT_ICW2;
            icw4_wanted = r.write_data[IcwFourBit];
            irr_model   = '0;
            isr_model   = '0;
            imr_model   = '0;
          end else if (!r.write_data[OcwThreeBit] && r.write_data[EoiBit]) begin
            if (r.write_data[SpecificBit]) begin
              isr_model[r.write_data[2:0]] = 1'b0;
            end else begin
              isr_model = isr_model & (isr_model - 8'd1);
            end
          end
        end else begin
          case (init_model)
            INIT_ICW2: begin
              base_model = r.write_data[7:3];
              init_model = icw4_wanted ? INIT_ICW4 : INIT_IDLE;
            end
            INIT_ICW4: init_model = INIT_IDLE;
            default:   imr_model = r.write_data;
          endcase
        end
      end
      ACT_READ:  res.read_data = r.port_odd ? imr_model : irr_model;
      ACT_RAISE: irr_model[r.irq_line] = 1'b1;
      ACT_LOWER: irr_model[r.irq_line] = 1'b0;
      ACT_ACK: begin
        pend = irr_model & ~imr_model;
        if (pend != '0) begin
          lvl = 8;
          for (int i = 7; i >= 0; i--) begin
            if (pend[i]) lvl = i;
          end
          upto = 8'((2 << lvl) - 1);
          if ((isr_model & upto) == '0) begin
            isr_model[lvl]    = 1'b1;
            irr_model[lvl]    = 1'b0;
            res.vector_valid  = 1'b1;
            res.vector_number = {base_model, 3'(lvl)};
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic add_request(logic [2:0] act, logic odd, logic [7:0] data, logic [2:0] line);
    pic_req_t r;
    r.action     = act;
    r.port_odd   = odd;
    r.write_data = data;
    r.irq_line   = line;
    pending_requests.push_back(r);
  endtask

  task automatic note_mismatch(string field, logic [7:0] want, logic [7:0] got);
    if (mismatches < MaxReported) begin
      $display("mismatch on response %0d, %s: expected 0x%02h, got 0x%02h",
               response_count, field, want, got);
    end
    mismatches++;
  endtask

  // Driver: a new request is presented only when the previous one has been taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        expected_responses.push_back(controller_response(current_request));
        accepted_count++;
      end
      if (pending_requests.size() != 0 &&
          ((accepted_count >= CalmFirst && accepted_count < CalmLast) ||
           $urandom_range(99) >= IdlePercent)) begin
        current_request = pending_requests.pop_front();
        in_valid_i     <= 1'b1;
        action_i       <= current_request.action;
        port_odd_i     <= current_request.port_odd;
        write_data_i   <= current_request.write_data;
        irq_line_i     <= current_request.irq_line;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: every accepted response is matched against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin : monitor_blk
    pic_res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_responses.size() == 0) begin
          if (mismatches < MaxReported) begin
            $display("unexpected response %0d: read 0x%02h valid %0b vector 0x%02h",
                     response_count, read_data_o, vector_valid_o, vector_number_o);
          end
          mismatches++;
        end else begin
          want = expected_responses.pop_front();
          if (read_data_o !== want.read_data)
            note_mismatch("read_data", want.read_data, read_data_o);
          if (vector_valid_o !== want.vector_valid)
            note_mismatch("vector_valid", 8'(want.vector_valid), 8'(vector_valid_o));
          if (vector_number_o !== want.vector_number)
            note_mismatch("vector_number", want.vector_number, vector_number_o);
          if (want.vector_valid) grants_seen++;
        end
        response_count++;
      end
      if (response_count >= CalmFirst && response_count < CalmLast) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < IdlePercent);
      end
    end
  end

  initial begin : stimulus_blk
    int         pick;
    int         random_start;
    logic [7:0] d;

    irr_model   = '0;
    isr_model   = '0;
    imr_model   = MaskResetVal;
    init_model  = INIT_IDLE;
    icw4_wanted = 1'b0;
    base_model  = '0;

    // Directed part: reset values, masking, priority blocking, both EOI forms, init words.
    add_request(ACT_READ,  1'b0, 8'h00, 3'd0);
    add_request(ACT_READ,  1'b1, 8'hFF, 3'd7);
    add_request(ACT_RAISE, 1'b0, 8'h00, 3'd7);
    add_request(ACT_RAISE, 1'b1, 8'hFF, 3'd0);
    add_request(ACT_ACK,   1'b0, 8'h00, 3'd0);
    add_request(ACT_WRITE, 1'b1, 8'h00, 3'd0);
    add_request(ACT_ACK,   1'b0, 8'h00, 3'd0);
    add_request(ACT_ACK,   1'b1, 8'hFF, 3'd7);
    add_request(ACT_WRITE, 1'b0, EoiCmd, 3'd0);
    add_request(ACT_ACK,   1'b0, 8'h00, 3'd0);
    add_request(ACT_WRITE, 1'b0, SpecEoiCmd | 8'd7, 3'd0);
    add_request(ACT_WRITE, 1'b0, Icw1Cmd | Icw4Flag, 3'd0);
    add_request(ACT_WRITE, 1'b1, 8'hFF, 3'd0);
    add_request(ACT_WRITE, 1'b1, 8'hFF, 3'd0);
    add_request(ACT_READ,  1'b1, 8'h00, 3'd0);
    add_request(ACT_RAISE, 1'b0, 8'h00, 3'd3);
    add_request(ACT_ACK,   1'b0, 8'h00, 3'd0);
    add_request(ACT_WRITE, 1'b0, Ocw3Cmd | EoiCmd, 3'd0);
    add_request(ACT_ACK,   1'b0, 8'h00, 3'd0);
    add_request(ACT_WRITE, 1'b0, Icw1Cmd, 3'd0);
    add_request(ACT_WRITE, 1'b1, 8'h00, 3'd0);
    add_request(ACT_WRITE, 1'b1, 8'hFF, 3'd0);
    add_request(ACT_RAISE, 1'b0, 8'h00, 3'd5);
    add_request(ACT_LOWER, 1'b1, 8'hFF, 3'd5);
    for (int a = int'(ACT_ACK) + 1; a < 8; a++) begin
      add_request(3'(a), 1'(a), 8'($urandom_range(255)), 3'($urandom_range(7)));
    end

    // Random part: mostly interrupt service traffic, some init sequences and some noise.
    random_start = pending_requests.size();
    while (pending_requests.size() < random_start + RandomItems) begin
      pick = $urandom_range(99);
      d    = 8'($urandom_range(255));
      if (pick < 5) begin
        d[IcwOneBit] = 1'b1;
        add_request(ACT_WRITE, 1'b0, d, 3'($urandom_range(7)));
        init_sequences++;
        if ($urandom_range(9) < 8) begin
          add_request(ACT_WRITE, 1'b1, 8'($urandom_range(255)), 3'($urandom_range(7)));
          if (d[IcwFourBit] && $urandom_range(9) < 8)
            add_request(ACT_WRITE, 1'b1, 8'($urandom_range(255)), 3'($urandom_range(7)));
        end
      end else if (pick < 15) begin
        add_request(3'($urandom_range(7)), 1'($urandom_range(1)), d, 3'($urandom_range(7)));
      end else if (pick < 33) begin
        add_request(ACT_RAISE, 1'($urandom_range(1)), d, 3'($urandom_range(7)));
      end else if (pick < 40) begin
        add_request(ACT_LOWER, 1'($urandom_range(1)), d, 3'($urandom_range(7)));
      end else if (pick < 62) begin
        add_request(ACT_ACK, 1'($urandom_range(1)), d, 3'($urandom_range(7)));
      end else if (pick < 76) begin
        d[IcwOneBit]   = 1'b0;
        d[OcwThreeBit] = 1'b0;
        d[EoiBit]      = 1'b1;
        add_request(ACT_WRITE, 1'b0, d, 3'($urandom_range(7)));
      end else if (pick < 85) begin
        add_request(ACT_READ, 1'($urandom_range(1)), d, 3'($urandom_range(7)));
      end else if (pick < 93) begin
        // Mostly sparse masks so that acknowledges still find lines to grant.
        d = d & 8'($urandom_range(255)) & 8'($urandom_range(255));
        add_request(ACT_WRITE, 1'b1, d, 3'($urandom_range(7)));
      end else begin
        d[IcwOneBit] = 1'b0;
        if ($urandom_range(1)) d[OcwThreeBit] = 1'b1;
        else                   d[EoiBit] = 1'b0;
        add_request(ACT_WRITE, 1'b0, d, 3'($urandom_range(7)));
      end
    end
    total_items = pending_requests.size();

    while (accepted_count < total_items) @(posedge clk_i);
    while (expected_responses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run drove %0d requests (%0d random) through %0d init sequences",
             total_items, total_items - random_start, init_sequences);
    $display("%0d responses checked, %0d of them granted vectors", response_count, grants_seen);
    if (mismatches == 0 && expected_responses.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("timeout with %0d requests accepted", accepted_count);
    $display("tb: failure");
    $finish;
  end

endmodule
